[src/assert_macros.svh]
// Assertion macros shared by the frame table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define ASSERT_ON_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  `ASSERT_ON_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

[src/pfto_pkg.sv]
// Shared types and constants of the frame table with oldest-first eviction.
package pfto_pkg;

  localparam int unsigned CFG_W       = 5;
  localparam logic [4:0]  CFG_RESET   = 5'd16;
  localparam int unsigned OPC_W       = 2;
  localparam int unsigned PID_W       = 16;
  localparam int unsigned PCNT_W      = 5;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned FRAME_OUT_W = 4;
  localparam int unsigned MAX_OUT     = 16;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_EVICT = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [OPC_W-1:0]   opcode;
    logic [PID_W-1:0]   proc_id;
    logic [PCNT_W-1:0]  page_count;
    logic [STAMP_W-1:0] now;
    logic [PID_W-1:0]   protect_id;
  } in_item_t;

  typedef struct packed {
    logic                   fits;
    logic                   evicted_valid;
    logic [FRAME_OUT_W-1:0] evicted_frame;
    logic                   last;
  } out_item_t;

endpackage

[src/pfto_if.sv]
// Valid/ready channel interfaces for request items and result items.
interface pfto_in_if;
  import pfto_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface pfto_out_if;
  import pfto_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/pfto_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pfto_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/page_frame_table_oldest_evict_core.sv]
// Top level of the frame table: allocate, free owner and evict-oldest sequencer.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+-------------------------------------------------
//  in_i    | in  | valid/ready      | opcode, proc_id, page_count, now, protect_id
//  out_o   | out | valid/ready      | fits, evicted_valid, evicted_frame, last
//  cfg     | in  | cfg_we_i only    | cfg_wdata_i -> frames_in_use
//
// One frame is compared per cycle on one shared compare unit fed by the owner and
// stamp RAMs, whose read data is registered. Allocate and free make one pass over the
// managed frames; evict makes one pass to count the protected owner's frames, then one
// oldest-search pass per evicted frame, then emits the evicted frames, if any.
// Reset clears all frames to free and frames_in_use to 16; no clearing pass is needed.
// in_i is ready only in idle; a stalled out_o holds the result and stalls the emit and response states.
`include "assert_macros.svh"

module page_frame_table_oldest_evict_core #(
  parameter int unsigned FRAMES  = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pfto_pkg::CFG_W-1:0] cfg_wdata_i,
  pfto_in_if.sink                   in_i,
  pfto_out_if.source                out_o
);
  import pfto_pkg::*;

  localparam int unsigned IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CNT_W   = $clog2(FRAMES + 1);
  localparam int unsigned STEP_W  = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
  localparam int unsigned TAKEN_W = $clog2(MAX_OUT + 1);

  // Configuration and sequencer state
  logic [CFG_W-1:0] cfg_q;
  state_e           state_q, state_d;

  // Latched request fields
  op_e                op_q, op_d;
  logic [ID_BITS-1:0] pid_q, pid_d;
  logic [ID_BITS-1:0] prot_q, prot_d;
  logic [STAMP_W-1:0] now_q, now_d;

  // Scan pipeline
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic             p_vld_q, p_vld_d;
  logic [IDX_W-1:0] p_idx_q, p_idx_d;
  logic             min_pass_q, min_pass_d;

  // Frame flags and eviction bookkeeping
  logic [FRAMES-1:0]        used_q, used_d;
  logic [FRAMES-1:0]        gone_q, gone_d;
  logic signed [STEP_W-1:0] steps_q, steps_d;
  logic [TAKEN_W-1:0]       taken_q, taken_d;
  logic [TAKEN_W-1:0]       emit_cnt_q, emit_cnt_d;
  logic [IDX_W-1:0]         emit_idx_q, emit_idx_d;
  logic                     found_q, found_d;
  logic [IDX_W-1:0]         best_idx_q, best_idx_d;
  logic [STAMP_W-1:0]       best_stamp_q, best_stamp_d;
  logic                     res_fits_q, res_fits_d;

  // Output register
  logic      out_vld_q, out_vld_d;
  out_item_t out_q, out_d;

  // Combinational helpers
  logic [CNT_W-1:0]         n_frames;
  logic [ID_BITS-1:0]       owner_rd;
  logic [STAMP_W-1:0]       stamp_rd;
  logic                     accept;
  logic                     issue;
  logic                     pass_end;
  logic                     cur_used;
  logic                     own_match, prot_match;
  logic                     claim, release_hit, prot_hit, cand;
  logic signed [STEP_W-1:0] steps_run, steps_min;
  logic                     found_final;
  logic [IDX_W-1:0]         best_final;
  logic [TAKEN_W-1:0]       taken_nx;
  logic                     min_more;
  logic                     out_free;
  logic                     emit_hit, emit_load, emit_last;
  logic                     resp_load;
  logic                     mem_we;

  // Clamp the managed frame count to the table size
  always_comb begin
    if (32'(cfg_q) > FRAMES) begin
      n_frames = CNT_W'(FRAMES);
    end else begin
      n_frames = CNT_W'(cfg_q);
    end
  end

  assign accept   = in_i.valid && in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;

  // Scan control: issue one read per cycle, process it in the next cycle
  assign issue    = (state_q == ST_SCAN) && (scan_cnt_q < n_frames);
  assign pass_end = (state_q == ST_SCAN) &&
                    ((n_frames == '0) ||
                     (p_vld_q && ((CNT_W'(p_idx_q) + CNT_W'(1)) == n_frames)));

  // Shared compare unit on the frame under inspection
  assign cur_used    = used_q[p_idx_q];
  assign own_match   = (owner_rd == pid_q);
  assign prot_match  = (owner_rd == prot_q);
  assign claim       = (state_q == ST_SCAN) && (op_q == OP_ALLOC) && p_vld_q &&
                       (!cur_used || own_match) && (steps_q > 0);
  assign release_hit = (state_q == ST_SCAN) && (op_q == OP_FREE) && p_vld_q &&
                       cur_used && own_match;
  assign prot_hit    = (state_q == ST_SCAN) && (op_q == OP_EVICT) && !min_pass_q &&
                       p_vld_q && cur_used && prot_match;
  assign cand        = (state_q == ST_SCAN) && (op_q == OP_EVICT) && min_pass_q &&
                       p_vld_q && cur_used && !prot_match &&
                       (!found_q || (stamp_rd < best_stamp_q));

  assign steps_run   = (claim || prot_hit) ? (steps_q - STEP_W'(1)) : steps_q;
  assign steps_min   = steps_q - STEP_W'(1);
  assign found_final = found_q || cand;
  assign best_final  = cand ? p_idx_q : best_idx_q;
  assign taken_nx    = taken_q + TAKEN_W'(found_final);
  assign min_more    = found_final && (steps_min > 0) && (taken_nx < TAKEN_W'(MAX_OUT));

  // Result emission
  assign emit_hit  = gone_q[emit_idx_q];
  assign emit_load = (state_q == ST_EMIT) && emit_hit && out_free;
  assign emit_last = ((emit_cnt_q + TAKEN_W'(1)) == taken_q);
  assign resp_load = (state_q == ST_RESP) && out_free;

  assign mem_we = claim;

  // Owner and stamp storage
  pfto_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (FRAMES)
  ) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (p_idx_q),
    .wdata_i (pid_q),
    .raddr_i (scan_cnt_q[IDX_W-1:0]),
    .rdata_o (owner_rd)
  );

  pfto_ram #(
    .WIDTH (STAMP_W),
    .DEPTH (FRAMES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (p_idx_q),
    .wdata_i (now_q),
    .raddr_i (scan_cnt_q[IDX_W-1:0]),
    .rdata_o (stamp_rd)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_e'(in_i.payload.opcode))
            OP_ALLOC, OP_FREE, OP_EVICT: state_d = ST_SCAN;
            default:                     state_d = ST_RESP;
          endcase
        end
      end
      ST_SCAN: begin
        if (pass_end) begin
          if (op_q != OP_EVICT) begin
            state_d = ST_RESP;
          end else if (!min_pass_q) begin
            state_d = (steps_run > 0) ? ST_SCAN : ST_RESP;
          end else if (min_more) begin
            state_d = ST_SCAN;
          end else begin
            state_d = (taken_nx == '0) ? ST_RESP : ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (emit_load && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    op_d         = op_q;
    pid_d        = pid_q;
    prot_d       = prot_q;
    now_d        = now_q;
    scan_cnt_d   = scan_cnt_q;
    p_vld_d      = 1'b0;
    p_idx_d      = p_idx_q;
    min_pass_d   = min_pass_q;
    used_d       = used_q;
    gone_d       = gone_q;
    steps_d      = steps_q;
    taken_d      = taken_q;
    emit_cnt_d   = emit_cnt_q;
    emit_idx_d   = emit_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    res_fits_d   = res_fits_q;
    out_vld_d    = out_vld_q && !out_o.ready;
    out_d        = out_q;

    // Latch a new item and clear per-item bookkeeping
    if (accept) begin
      op_d       = op_e'(in_i.payload.opcode);
      pid_d      = ID_BITS'(in_i.payload.proc_id);
      prot_d     = ID_BITS'(in_i.payload.protect_id);
      now_d      = in_i.payload.now;
      steps_d    = STEP_W'(in_i.payload.page_count);
      scan_cnt_d = '0;
      min_pass_d = 1'b0;
      gone_d     = '0;
      taken_d    = '0;
      emit_cnt_d = '0;
      emit_idx_d = '0;
      found_d    = 1'b0;
      res_fits_d = 1'b0;
    end

    // Advance the read pipeline
    if (issue) begin
      p_vld_d    = 1'b1;
      p_idx_d    = scan_cnt_q[IDX_W-1:0];
      scan_cnt_d = scan_cnt_q + CNT_W'(1);
    end

    // Apply the per-frame decision
    if (state_q == ST_SCAN) begin
      steps_d = steps_run;
    end
    if (claim) begin
      used_d[p_idx_q] = 1'b1;
    end
    if (release_hit) begin
      used_d[p_idx_q] = 1'b0;
    end
    if (cand) begin
      found_d      = 1'b1;
      best_idx_d   = p_idx_q;
      best_stamp_d = stamp_rd;
    end

    // Close a pass
    if (pass_end) begin
      scan_cnt_d = '0;
      p_vld_d    = 1'b0;
      if (op_q == OP_ALLOC) begin
        res_fits_d = (steps_run == '0);
      end
      if (op_q == OP_EVICT) begin
        if (!min_pass_q) begin
          min_pass_d = 1'b1;
        end else begin
          steps_d = steps_min;
          if (found_final) begin
            used_d[best_final] = 1'b0;
            gone_d[best_final] = 1'b1;
            taken_d            = taken_nx;
          end
        end
        found_d = 1'b0;
      end
    end

    // Walk the evicted set in ascending order
    if ((state_q == ST_EMIT) && (!emit_hit || emit_load)) begin
      emit_idx_d = emit_idx_q + IDX_W'(1);
    end
    if (emit_load) begin
      emit_cnt_d          = emit_cnt_q + TAKEN_W'(1);
      out_vld_d           = 1'b1;
      out_d.fits          = 1'b0;
      out_d.evicted_valid = 1'b1;
      out_d.evicted_frame = FRAME_OUT_W'(emit_idx_q);
      out_d.last          = emit_last;
    end

    // Single result
    if (resp_load) begin
      out_vld_d           = 1'b1;
      out_d.fits          = res_fits_q;
      out_d.evicted_valid = 1'b0;
      out_d.evicted_frame = '0;
      out_d.last          = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q      <= CFG_RESET;
      state_q    <= ST_IDLE;
      scan_cnt_q <= '0;
      p_vld_q    <= 1'b0;
      min_pass_q <= 1'b0;
      used_q     <= '0;
      gone_q     <= '0;
      taken_q    <= '0;
      emit_cnt_q <= '0;
      emit_idx_q <= '0;
      found_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      state_q    <= state_d;
      scan_cnt_q <= scan_cnt_d;
      p_vld_q    <= p_vld_d;
      min_pass_q <= min_pass_d;
      used_q     <= used_d;
      gone_q     <= gone_d;
      taken_q    <= taken_d;
      emit_cnt_q <= emit_cnt_d;
      emit_idx_q <= emit_idx_d;
      found_q    <= found_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    pid_q        <= pid_d;
    prot_q       <= prot_d;
    now_q        <= now_d;
    p_idx_q      <= p_idx_d;
    steps_q      <= steps_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    res_fits_q   <= res_fits_d;
    out_q        <= out_d;
  end

  assign in_i.ready    = (state_q == ST_IDLE);
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_q;

  // Checks
  `ASSERT_IMPLIES(a_idle_pipe_empty, clk_i, rst_ni, in_i.ready, !p_vld_q && (scan_cnt_q == '0), "scan pipeline busy while ready")
  `ASSERT_IMPLIES(a_write_alloc_only, clk_i, rst_ni, mem_we, (state_q == ST_SCAN) && (op_q == OP_ALLOC), "frame write outside allocate scan")
  `ASSERT_ON_CLK(a_taken_cap, clk_i, rst_ni, taken_q <= TAKEN_W'(MAX_OUT), "evicted count above limit")
  `ASSERT_ON_CLK(a_busy_after_accept, clk_i, rst_ni, (in_i.valid && in_i.ready) |=> !in_i.ready, "ready right after accept")

endmodule

[bench/tb.sv]
// Self-checking bench for the frame table: allocate, free owner and oldest-first evict.
module tb;
  import pfto_pkg::*;

  localparam int          NSLOT      = 16;
  localparam int          DIR_N      = 23;
  localparam int          PHASE_N    = 6;
  localparam int          PHASE_REQS = 15;
  localparam int          IDLE_LIMIT = 4000;
  localparam int          HOLD_LEN   = 300;
  localparam out_item_t   R_DONE     = '{fits: 1'b0, evicted_valid: 1'b0,
                                         evicted_frame: '0, last: 1'b1};
  localparam out_item_t   R_FIT      = '{fits: 1'b1, evicted_valid: 1'b0,
                                         evicted_frame: '0, last: 1'b1};

  typedef struct {
    op_e                op;
    logic [PID_W-1:0]   pid;
    logic [PCNT_W-1:0]  cnt;
    logic [STAMP_W-1:0] stamp;
    logic [PID_W-1:0]   prot;
    bit                 typed;
    out_item_t          res;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  pfto_in_if  req_ch ();
  pfto_out_if rsp_ch ();

  page_frame_table_oldest_evict_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_ch),
    .out_o       (rsp_ch)
  );

  // Shadow of the frame table
  logic               slot_busy [NSLOT];
  logic [PID_W-1:0]   slot_pid  [NSLOT];
  logic [STAMP_W-1:0] slot_time [NSLOT];
  logic [CFG_W-1:0]   span_reg;

  out_item_t   step_results [$];
  out_item_t   pending_results [$];
  int          errors;
  int          reqs_sent;
  int          results_seen;
  int          evictions_seen;
  int          fits_seen;
  int          idle_cycles;
  logic [PID_W-1:0]   id_pool [4];
  logic [STAMP_W-1:0] clock_now;
  logic [CFG_W-1:0]   phase_span [PHASE_N];

  // Directed requests, starting from an empty table of 16 frames
  dir_row_t dir_rows [DIR_N] = '{
    // evict on an empty table finds nothing
    '{OP_EVICT, 16'h0000, 5'd3,  32'd0,          16'h0000, 1'b1, R_DONE},
    // zero pages always fit
    '{OP_ALLOC, 16'h0001, 5'd0,  32'd5,          16'h0000, 1'b1, R_FIT},
    '{OP_ALLOC, 16'h0001, 5'd4,  32'd10,         16'h0000, 1'b1, R_FIT},
    // only 12 free frames left, claims stay
    '{OP_ALLOC, 16'hFFFF, 5'd16, 32'd20,         16'h0000, 1'b1, R_DONE},
    // unused opcode with all-ones fields
    '{OP_NONE,  16'hFFFF, 5'd31, 32'hFFFF_FFFF,  16'hFFFF, 1'b1, R_DONE},
    // owned frames cover the request
    '{OP_EVICT, 16'h0000, 5'd2,  32'd0,          16'h0001, 1'b1, R_DONE},
    // equal stamps, lowest index first
    '{OP_EVICT, 16'h0000, 5'd6,  32'd0,          16'h0001, 1'b0, R_DONE},
    '{OP_ALLOC, 16'h0001, 5'd16, 32'hFFFF_FFFF,  16'h0000, 1'b0, R_DONE},
    '{OP_FREE,  16'hFFFF, 5'd0,  32'd0,          16'h0000, 1'b1, R_DONE},
    '{OP_ALLOC, 16'h0002, 5'd10, 32'd0,          16'h0000, 1'b0, R_DONE},
    // evict every frame, sixteen results
    '{OP_EVICT, 16'h0000, 5'd31, 32'd0,          16'hFFFF, 1'b0, R_DONE},
    '{OP_ALLOC, 16'h8000, 5'd31, 32'h8000_0000,  16'h0000, 1'b0, R_DONE},
    '{OP_FREE,  16'h7FFF, 5'd0,  32'd0,          16'h0000, 1'b1, R_DONE},
    '{OP_FREE,  16'h8000, 5'd0,  32'd0,          16'h0000, 1'b1, R_DONE},
    // request met exactly on the last frame
    '{OP_ALLOC, 16'h5555, 5'd16, 32'd7,          16'h0000, 1'b1, R_FIT},
    // every frame protected
    '{OP_EVICT, 16'h0000, 5'd1,  32'd0,          16'h5555, 1'b1, R_DONE},
    '{OP_EVICT, 16'h0000, 5'd17, 32'd0,          16'hAAAA, 1'b0, R_DONE},
    '{OP_ALLOC, 16'h0AAA, 5'd3,  32'd100,        16'h0000, 1'b0, R_DONE},
    '{OP_ALLOC, 16'h0555, 5'd2,  32'd50,         16'h0000, 1'b0, R_DONE},
    // own frame gets a fresh stamp
    '{OP_ALLOC, 16'h0AAA, 5'd1,  32'd30,         16'h0000, 1'b0, R_DONE},
    '{OP_EVICT, 16'h0000, 5'd2,  32'd0,          16'h0000, 1'b0, R_DONE},
    // fewer candidates than eviction steps
    '{OP_EVICT, 16'h0000, 5'd5,  32'd0,          16'h0AAA, 1'b0, R_DONE},
    '{OP_FREE,  16'h0AAA, 5'd0,  32'd0,          16'h0000, 1'b1, R_DONE}
  };

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Work out the results of one request and update the shadow table
  task automatic apply_request(input in_item_t req);
    int        span;
    int        left;
    int        taken;
    int        k;
    int        best;
    int        i;
    bit        found;
    bit        gone [NSLOT];
    out_item_t r;
    span = (span_reg > NSLOT) ? NSLOT : int'(span_reg);
    step_results.delete();
    r = R_DONE;
    case (op_e'(req.opcode))
      OP_ALLOC: begin
        left = int'(req.page_count);
        for (i = 0; i < span && left > 0; i++) begin
          if (!slot_busy[i] || slot_pid[i] == req.proc_id) begin
            slot_busy[i] = 1'b1;
            slot_pid[i]  = req.proc_id;
            slot_time[i] = req.now;
            left--;
          end
        end
        r.fits = (left == 0);
        step_results.push_back(r);
      end
      OP_FREE: begin
        for (i = 0; i < span; i++) begin
          if (slot_busy[i] && slot_pid[i] == req.proc_id) begin
            slot_busy[i] = 1'b0;
            slot_time[i] = '0;
          end
        end
        step_results.push_back(r);
      end
      OP_EVICT: begin
        left  = int'(req.page_count);
        taken = 0;
        for (i = 0; i < NSLOT; i++) gone[i] = 1'b0;
        // frames the protected owner holds count against the request
        for (i = 0; i < span; i++) begin
          if (slot_busy[i] && slot_pid[i] == req.protect_id) left--;
        end
        while (left > 0 && taken < MAX_OUT) begin
          found = 1'b0;
          best  = 0;
          for (i = 0; i < span; i++) begin
            if (slot_busy[i] && slot_pid[i] != req.protect_id &&
                (!found || slot_time[i] < slot_time[best])) begin
              found = 1'b1;
              best  = i;
            end
          end
          if (found) begin
            slot_busy[best] = 1'b0;
            slot_time[best] = '0;
            gone[best]      = 1'b1;
            taken++;
          end
          left--;
        end
        if (taken == 0) begin
          step_results.push_back(r);
        end else begin
          k = 0;
          for (i = 0; i < span; i++) begin
            if (gone[i]) begin
              r.evicted_valid = 1'b1;
              r.evicted_frame = FRAME_OUT_W'(i);
              r.last          = (k + 1 == taken);
              step_results.push_back(r);
              k++;
            end
          end
        end
      end
      default: step_results.push_back(r);
    endcase
  endtask

  // Offer one request, wait for it to be taken, then queue its results
  task automatic send_request(input in_item_t req, input bit typed, input out_item_t res);
    bit calm;
    @(negedge clk_i);
    calm = (reqs_sent >= 70 && reqs_sent < 100);
    if (!calm && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 8);
    end
    req_ch.valid   <= 1'b1;
    req_ch.payload <= req;
    do @(posedge clk_i); while (!req_ch.ready);
    reqs_sent++;
    apply_request(req);
    if (typed) pending_results.push_back(res);
    else foreach (step_results[j]) pending_results.push_back(step_results[j]);
  endtask

  // Drop valid and let every queued result drain before touching the register
  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic write_span(input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    span_reg = val;
  endtask

  // Build one random request, mostly from a small pool of owners
  function automatic in_item_t make_request();
    in_item_t req;
    int       pick;
    pick = $urandom_range(99);
    if (pick < 45)      req.opcode = OP_ALLOC;
    else if (pick < 65) req.opcode = OP_FREE;
    else if (pick < 93) req.opcode = OP_EVICT;
    else                req.opcode = OP_NONE;
    req.proc_id    = ($urandom_range(9) == 0) ? PID_W'($urandom) : id_pool[$urandom_range(3)];
    req.protect_id = ($urandom_range(9) == 0) ? PID_W'($urandom) : id_pool[$urandom_range(3)];
    pick = $urandom_range(99);
    if (pick < 80)      req.page_count = PCNT_W'($urandom_range(6));
    else if (pick < 95) req.page_count = PCNT_W'($urandom_range(16));
    else                req.page_count = PCNT_W'($urandom_range(31, 17));
    // time mostly moves forward, with repeats for ties
    clock_now = clock_now + STAMP_W'($urandom_range(20));
    req.now   = ($urandom_range(9) == 0) ? STAMP_W'($urandom) : clock_now;
    return req;
  endfunction

  // Receiver: random stalls, one long hold-off, a calm window
  initial begin
    int  hold_left;
    bit  hold_done;
    bit  calm;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      calm = (reqs_sent >= 70 && reqs_sent < 100);
      if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && reqs_sent >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t got;
    out_item_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.payload;
      results_seen++;
      if (got.evicted_valid) evictions_seen++;
      if (got.fits) fits_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.fits !== want.fits) begin
          $error("fits: expected %0b, got %0b", want.fits, got.fits);
          errors++;
        end
        if (got.evicted_valid !== want.evicted_valid) begin
          $error("evicted_valid: expected %0b, got %0b", want.evicted_valid, got.evicted_valid);
          errors++;
        end
        if (got.evicted_frame !== want.evicted_frame) begin
          $error("evicted_frame: expected %0d, got %0d", want.evicted_frame, got.evicted_frame);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence
  initial begin
    in_item_t req;
    int       p;
    int       r;
    req_ch.valid   = 1'b0;
    req_ch.payload = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    rst_ni         = 1'b0;
    idle_cycles    = 0;
    errors         = 0;
    reqs_sent      = 0;
    results_seen   = 0;
    evictions_seen = 0;
    fits_seen      = 0;
    clock_now      = '0;
    span_reg       = CFG_RESET;
    for (r = 0; r < NSLOT; r++) begin
      slot_busy[r] = 1'b0;
      slot_pid[r]  = '0;
      slot_time[r] = '0;
    end
    phase_span[0] = 5'd1;
    phase_span[1] = 5'd31;
    phase_span[2] = 5'd0;
    phase_span[3] = 5'd9;
    phase_span[4] = 5'd16;
    phase_span[5] = CFG_W'($urandom_range(16, 1));

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part
    for (r = 0; r < DIR_N; r++) begin
      req.opcode     = dir_rows[r].op;
      req.proc_id    = dir_rows[r].pid;
      req.page_count = dir_rows[r].cnt;
      req.now        = dir_rows[r].stamp;
      req.protect_id = dir_rows[r].prot;
      send_request(req, dir_rows[r].typed, dir_rows[r].res);
    end
    drain_results();

    // Random part, one frame-count setting per phase
    for (p = 0; p < PHASE_N; p++) begin
      id_pool[0] = PID_W'($urandom);
      id_pool[1] = PID_W'($urandom_range(3));
      id_pool[2] = PID_W'($urandom);
      id_pool[3] = 16'hFFFF - PID_W'($urandom_range(1));
      write_span(phase_span[p]);
      for (r = 0; r < PHASE_REQS; r++) send_request(make_request(), 1'b0, R_DONE);
      drain_results();
    end

    repeat (40) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      errors++;
    end

    $display("Ran %0d requests over %0d frame-count settings; checked %0d results",
             reqs_sent, PHASE_N + 1, results_seen);
    $display("including %0d evicted frames and %0d fitting allocations.",
             evictions_seen, fits_seen);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
